>>> src/tgsg_pkg.sv
package tgsg_pkg;

    localparam int COORD_W      = 24;
    localparam int SCALE_W      = 8;
    localparam int COLOR_W      = 32;
    localparam int COUNT_W      = 17;
    localparam int CODE_W       = 8;
    localparam int STEP_W       = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int FONT_COLS     = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_BITS    = FONT_COLS * GLYPH_ROWS;
    localparam int ROW_W         = 3;
    localparam int SEGLEN_W      = 8;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RESET    = 8'd16;
    localparam logic [COLOR_W-1:0] COLOR_RESET    = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 17'h10000;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;

    // floor(4*s/5) = (s*820) >> 10, exact for s below 256
    localparam int SEGLEN_MUL   = 820;
    localparam int SEGLEN_SHIFT = 10;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SCAN    = 7'b0000010,
        ST_X0      = 7'b0000100,
        ST_X1      = 7'b0001000,
        ST_Y       = 7'b0010000,
        ST_ADV     = 7'b0100000,
        ST_NEWLINE = 7'b1000000
    } state_t;

endpackage

>>> src/tgsg_font_rom.sv
module tgsg_font_rom (
    input  logic [tgsg_pkg::CODE_W-1:0]     code,
    output logic [tgsg_pkg::GLYPH_BITS-1:0] mask
);

    logic [tgsg_pkg::CODE_W-1:0] upper;
    logic [39:0]                 cols;

    // columns listed first to last, column 0 in the top byte
    function automatic logic [39:0] font_cols(input logic [tgsg_pkg::CODE_W-1:0] c);
        logic [39:0] r;
        case (c)
            8'h30: r = 40'h3e5149453e;
            8'h31: r = 40'h00427f4000;
            8'h32: r = 40'h4261514946;
            8'h33: r = 40'h2141454b31;
            8'h34: r = 40'h1814127f10;
            8'h35: r = 40'h2745454539;
            8'h36: r = 40'h3c4a494930;
            8'h37: r = 40'h0171090503;
            8'h38: r = 40'h3649494936;
            8'h39: r = 40'h064949291e;
            8'h41: r = 40'h7e1111117e;
            8'h42: r = 40'h7f49494936;
            8'h43: r = 40'h3e41414122;
            8'h44: r = 40'h7f4141221c;
            8'h45: r = 40'h7f49494941;
            8'h46: r = 40'h7f09090901;
            8'h47: r = 40'h3e4149497a;
            8'h48: r = 40'h7f0808087f;
            8'h49: r = 40'h00417f4100;
            8'h4a: r = 40'h2040413f01;
            8'h4b: r = 40'h7f08142241;
            8'h4c: r = 40'h7f40404040;
            8'h4d: r = 40'h7f020c027f;
            8'h4e: r = 40'h7f0408107f;
            8'h4f: r = 40'h3e4141413e;
            8'h50: r = 40'h7f09090906;
            8'h51: r = 40'h3e4151215e;
            8'h52: r = 40'h7f09192946;
            8'h53: r = 40'h4649494931;
            8'h54: r = 40'h01017f0101;
            8'h55: r = 40'h3f4040403f;
            8'h56: r = 40'h1f2040201f;
            8'h57: r = 40'h3f4038403f;
            8'h58: r = 40'h6314081463;
            8'h59: r = 40'h0708700807;
            8'h5a: r = 40'h6151494543;
            8'h3a: r = 40'h0000140000;
            8'h2e: r = 40'h0000400000;
            8'h2d: r = 40'h0008080800;
            default: r = 40'h0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (code inside {[8'h61:8'h7a]})
            upper = code - 8'h20;
        else
            upper = code;
    end

    assign cols = font_cols(upper);

    // bit c*7+r is pixel (column c, row r)
    always_comb
    begin
        for (int c = 0; c < tgsg_pkg::FONT_COLS; c++)
        begin
            mask[c*tgsg_pkg::GLYPH_ROWS +: tgsg_pkg::GLYPH_ROWS] =
                cols[(4-c)*8 +: tgsg_pkg::GLYPH_ROWS];
        end
    end

endmodule

>>> src/tgsg_sat_add.sv
module tgsg_sat_add (
    input  logic signed [tgsg_pkg::COORD_W-1:0] a,
    input  logic        [tgsg_pkg::STEP_W-1:0]  b,
    output logic signed [tgsg_pkg::COORD_W-1:0] sum
);

    logic signed [tgsg_pkg::COORD_W:0] wide;

    assign wide = {a[tgsg_pkg::COORD_W-1], a}
                + $signed({{(tgsg_pkg::COORD_W+1-tgsg_pkg::STEP_W){1'b0}}, b});

    // b is never negative, so only the top clamps
    always_comb
    begin
        if (wide[tgsg_pkg::COORD_W] != wide[tgsg_pkg::COORD_W-1])
            sum = tgsg_pkg::COORD_MAX;
        else
            sum = wide[tgsg_pkg::COORD_W-1:0];
    end

endmodule

>>> src/text_glyph_segment_generator.sv
// Each lit pixel takes a scan step, then three shared-adder passes, the last of which waits
// while the output register is full and not taken; each unlit pixel before the last lit one
// takes a scan step, and the x advance comes last. A new character is accepted only in idle;
// ignored ones stay there, a newline takes a y step, a blank glyph a scan and the x advance.
// An output register holds a word while the adder works on the next one.
// Reset: async, active low; clears cursor, vertex count, abort flag, loads register defaults.
module text_glyph_segment_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tgsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgsg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // char_code
    input  logic [1:0]                        s_axis_tuser,  // first_char, new_list
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [103:0]                      m_axis_tdata,  // seg_x_start, seg_x_end,
                                                             // seg_y, seg_color
    output logic                              m_axis_tlast,  // last_of_char
    output logic                              m_axis_tuser   // overflow
);

    localparam int CW = tgsg_pkg::COORD_W;

    logic signed [CW-1:0]                 origin_x_reg, origin_y_reg;
    logic [tgsg_pkg::SCALE_W-1:0]         scale_reg;
    logic [tgsg_pkg::COLOR_W-1:0]         color_reg;
    logic [tgsg_pkg::COUNT_W-1:0]         capacity_reg;

    tgsg_pkg::state_t                     state_reg, state_next;
    logic signed [CW-1:0]                 cursor_x_reg, cursor_x_next;
    logic signed [CW-1:0]                 cursor_y_reg, cursor_y_next;
    logic [tgsg_pkg::COUNT_W-1:0]         vcount_reg, vcount_next;
    logic                                 aborted_reg, aborted_next;
    logic [tgsg_pkg::GLYPH_BITS-1:0]      glyph_reg, glyph_next;
    logic [tgsg_pkg::ROW_W-1:0]           row_reg, row_next;
    logic [10:0]                          row_off_reg, row_off_next;
    logic [9:0]                           col_off_reg, col_off_next;
    logic [tgsg_pkg::SEGLEN_W-1:0]        seglen_reg, seglen_next;
    logic signed [CW-1:0]                 x0_reg, x0_next;
    logic signed [CW-1:0]                 x1_reg, x1_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [CW-1:0]                        out_xs_reg, out_xs_next;
    logic [CW-1:0]                        out_xe_reg, out_xe_next;
    logic [CW-1:0]                        out_y_reg, out_y_next;
    logic [tgsg_pkg::COLOR_W-1:0]         out_color_reg, out_color_next;
    logic                                 out_last_reg, out_last_next;
    logic                                 out_ovf_reg, out_ovf_next;

    logic [tgsg_pkg::GLYPH_BITS-1:0]      rom_mask;
    logic signed [CW-1:0]                 sat_a, sat_sum;
    logic [tgsg_pkg::STEP_W-1:0]          sat_b;
    logic [10:0]                          scale_x6;
    logic [11:0]                          scale_x9;
    logic [17:0]                          seglen_prod;
    logic                                 out_free;
    logic                                 room_ok;
    logic                                 in_first, in_new_list;

    assign in_first    = s_axis_tuser[0];
    assign in_new_list = s_axis_tuser[1];

    tgsg_font_rom u_rom (
        .code (s_axis_tdata),
        .mask (rom_mask)
    );

    tgsg_sat_add u_add (
        .a   (sat_a),
        .b   (sat_b),
        .sum (sat_sum)
    );

    assign scale_x6    = {1'b0, scale_reg, 2'b00} + {2'b00, scale_reg, 1'b0};
    assign scale_x9    = {1'b0, scale_reg, 3'b000} + {4'b0000, scale_reg};
    assign seglen_prod = 18'(scale_reg) * 18'(tgsg_pkg::SEGLEN_MUL);
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign room_ok     = ({1'b0, vcount_reg} + 18'd2) <= {1'b0, capacity_reg};

    assign s_axis_tready = (state_reg == tgsg_pkg::ST_IDLE);

    // operand select for the shared adder
    always_comb
    begin
        sat_a = cursor_x_reg;
        sat_b = '0;
        case (state_reg)
            tgsg_pkg::ST_X0:
            begin
                sat_b = 12'(col_off_reg);
            end
            tgsg_pkg::ST_X1:
            begin
                sat_b = 12'(col_off_reg) + 12'(seglen_reg);
            end
            tgsg_pkg::ST_Y:
            begin
                sat_a = cursor_y_reg;
                sat_b = 12'(row_off_reg);
            end
            tgsg_pkg::ST_ADV:
            begin
                sat_b = 12'(scale_x6);
            end
            tgsg_pkg::ST_NEWLINE:
            begin
                sat_a = cursor_y_reg;
                sat_b = scale_x9;
            end
            default:
            begin
                sat_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        vcount_next    = vcount_reg;
        aborted_next   = aborted_reg;
        glyph_next     = glyph_reg;
        row_next       = row_reg;
        row_off_next   = row_off_reg;
        col_off_next   = col_off_reg;
        seglen_next    = seglen_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_xs_next    = out_xs_reg;
        out_xe_next    = out_xe_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            tgsg_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_new_list)
                        vcount_next = '0;
                    if (in_first)
                    begin
                        cursor_x_next = origin_x_reg;
                        cursor_y_next = origin_y_reg;
                        aborted_next  = 1'b0;
                    end
                    if ((aborted_reg && !in_first) || scale_reg == '0)
                    begin
                        state_next = tgsg_pkg::ST_IDLE;
                    end
                    else if (s_axis_tdata == tgsg_pkg::CODE_NEWLINE)
                    begin
                        cursor_x_next = origin_x_reg;
                        state_next    = tgsg_pkg::ST_NEWLINE;
                    end
                    else
                    begin
                        glyph_next   = rom_mask;
                        row_next     = '0;
                        row_off_next = '0;
                        col_off_next = '0;
                        seglen_next  = seglen_prod[tgsg_pkg::SEGLEN_SHIFT +: tgsg_pkg::SEGLEN_W];
                        state_next   = tgsg_pkg::ST_SCAN;
                    end
                end
            end
            tgsg_pkg::ST_SCAN:
            begin
                if (glyph_reg == '0)
                begin
                    state_next = tgsg_pkg::ST_ADV;
                end
                else if (!glyph_reg[0])
                begin
                    glyph_next = glyph_reg >> 1;
                    if (row_reg == tgsg_pkg::ROW_W'(tgsg_pkg::GLYPH_ROWS - 1))
                    begin
                        row_next     = '0;
                        row_off_next = '0;
                        col_off_next = col_off_reg + 10'(scale_reg);
                    end
                    else
                    begin
                        row_next     = row_reg + 1'b1;
                        row_off_next = row_off_reg + 11'(scale_reg);
                    end
                end
                else if (room_ok)
                begin
                    state_next = tgsg_pkg::ST_X0;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_xs_next    = '0;
                    out_xe_next    = '0;
                    out_y_next     = '0;
                    out_color_next = '0;
                    out_last_next  = 1'b1;
                    out_ovf_next   = 1'b1;
                    aborted_next   = 1'b1;
                    state_next     = tgsg_pkg::ST_IDLE;
                end
            end
            tgsg_pkg::ST_X0:
            begin
                x0_next    = sat_sum;
                state_next = tgsg_pkg::ST_X1;
            end
            tgsg_pkg::ST_X1:
            begin
                x1_next    = sat_sum;
                state_next = tgsg_pkg::ST_Y;
            end
            tgsg_pkg::ST_Y:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_xs_next    = x0_reg;
                    out_xe_next    = x1_reg;
                    out_y_next     = sat_sum;
                    out_color_next = color_reg;
                    out_last_next  = (glyph_reg[tgsg_pkg::GLYPH_BITS-1:1] == '0);
                    out_ovf_next   = 1'b0;
                    vcount_next    = vcount_reg + 17'd2;
                    glyph_next     = glyph_reg >> 1;
                    if (row_reg == tgsg_pkg::ROW_W'(tgsg_pkg::GLYPH_ROWS - 1))
                    begin
                        row_next     = '0;
                        row_off_next = '0;
                        col_off_next = col_off_reg + 10'(scale_reg);
                    end
                    else
                    begin
                        row_next     = row_reg + 1'b1;
                        row_off_next = row_off_reg + 11'(scale_reg);
                    end
                    state_next = (glyph_reg[tgsg_pkg::GLYPH_BITS-1:1] == '0) ?
                                 tgsg_pkg::ST_ADV : tgsg_pkg::ST_SCAN;
                end
            end
            tgsg_pkg::ST_ADV:
            begin
                cursor_x_next = sat_sum;
                state_next    = tgsg_pkg::ST_IDLE;
            end
            tgsg_pkg::ST_NEWLINE:
            begin
                cursor_y_next = sat_sum;
                state_next    = tgsg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tgsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= tgsg_pkg::SCALE_RESET;
            color_reg    <= tgsg_pkg::COLOR_RESET;
            capacity_reg <= tgsg_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgsg_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data[CW-1:0];
                tgsg_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data[CW-1:0];
                tgsg_pkg::CFG_SCALE:    scale_reg    <= cfg_data[tgsg_pkg::SCALE_W-1:0];
                tgsg_pkg::CFG_COLOR:    color_reg    <= cfg_data[tgsg_pkg::COLOR_W-1:0];
                tgsg_pkg::CFG_CAPACITY: capacity_reg <= cfg_data[tgsg_pkg::COUNT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tgsg_pkg::ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            vcount_reg    <= '0;
            aborted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            vcount_reg    <= vcount_next;
            aborted_reg   <= aborted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        row_reg       <= row_next;
        row_off_reg   <= row_off_next;
        col_off_reg   <= col_off_next;
        seglen_reg    <= seglen_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        out_xs_reg    <= out_xs_next;
        out_xe_reg    <= out_xe_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_y_reg, out_xe_reg, out_xs_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        !vcount_reg[0])
        else $error("vertex count is odd");

    a_abort_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(aborted_reg) |-> (state_reg == tgsg_pkg::ST_IDLE) && out_valid_reg && out_ovf_reg)
        else $error("abort without overflow word");

    a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("overflow word malformed");

endmodule
